// ===== src/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg: shared definitions for the audio module frame receiver
// Holds the frame constants, the byte position type and the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

	localparam logic [7:0] FRAME_START = 8'h7E;
	localparam logic [7:0] FRAME_END   = 8'hEF;
	localparam int         FRAME_LEN   = 10;

	localparam int POS_W = 4;
	typedef logic [POS_W-1:0] pos_t;

	// Named byte positions within a frame.
	localparam pos_t POS_START  = pos_t'(0);
	localparam pos_t POS_FIRST  = pos_t'(1);
	localparam pos_t POS_SUMEND = pos_t'(6);
	localparam pos_t POS_CMD    = pos_t'(3);
	localparam pos_t POS_PAR_HI = pos_t'(5);
	localparam pos_t POS_PAR_LO = pos_t'(6);
	localparam pos_t POS_CHK_HI = pos_t'(7);
	localparam pos_t POS_CHK_LO = pos_t'(8);
	localparam pos_t POS_LAST   = pos_t'(FRAME_LEN - 1);

	// Result word as carried on the output tdata, command in the low bits.
	typedef struct packed {
		logic [15:0] frame_param;
		logic [7:0]  frame_cmd;
	} result_t;

endpackage

`default_nettype wire

// ===== src/audio_module_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// audio_module_frame_receiver: serial reply frame parser
// Hunts for a start byte, collects a ten byte frame, checks the end byte and
// the checksum, and emits the command byte and parameter of a good frame.
// ----------------------------------------------------------------------------
// A good frame's result is registered in the output register or skid entry.
// Throughput: one input word per cycle; the running checksum and the fields
//   are updated per word, and a result register with a skid entry behind it
//   keeps input flowing while a result waits (s_tready falls only when full).
// Reset (arst_n low, asynchronous): the parser returns to hunting for the
//   start byte and both output entries are emptied.
`timescale 1ns / 1ps
`default_nettype none

module audio_module_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream: one word per received serial byte.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] line_error
	// Output stream: one word per validated frame.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [7:0] frame_cmd, [23:8] frame_param
);

	import afr_pkg::*;

	// Parser state.
	pos_t        pos_q;
	logic [15:0] sum_q;      // running sum of bytes one to six
	logic [7:0]  cmd_q;
	logic [7:0]  par_hi_q;
	logic [7:0]  par_lo_q;
	logic [7:0]  chk_hi_q;
	logic        chk_ok_q;   // checksum held once the low check byte arrived

	// Output stage.
	logic        out_valid_q;
	result_t     out_data_q;
	logic        skid_valid_q;
	result_t     skid_data_q;

	logic        in_take;
	logic        out_take;
	logic        res_valid;
	result_t     res_data;
	logic [15:0] chk_total;

	assign s_tready = !skid_valid_q;
	assign in_take  = s_tvalid && s_tready;
	assign out_take = out_valid_q && m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The checksum holds when the byte sum plus the check word wraps to zero.
	assign chk_total = sum_q + {chk_hi_q, s_tdata};

	// A result is produced when the final byte of a frame is accepted, the
	// end byte matches and the checksum was found good one byte earlier.
	always_comb begin
		res_valid            = in_take && !s_tuser && (pos_q == POS_LAST) &&
		                       (s_tdata == FRAME_END) && chk_ok_q;
		res_data.frame_cmd   = cmd_q;
		res_data.frame_param = {par_hi_q, par_lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_START;
		end else if (in_take) begin
			if (s_tuser) begin
				// A line error drops the byte and restarts the hunt.
				pos_q <= POS_START;
			end else if (pos_q == POS_START) begin
				if (s_tdata == FRAME_START) begin
					pos_q <= POS_FIRST;
				end
			end else if (pos_q >= POS_LAST) begin
				// The final byte always ends the frame, good or bad.
				pos_q <= POS_START;
			end else begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	// Frame fields need no reset: each is written before it is used.
	always_ff @(posedge clk) begin
		if (in_take && !s_tuser) begin
			if (pos_q == POS_FIRST) begin
				sum_q <= {8'h00, s_tdata};
			end else if (pos_q > POS_FIRST && pos_q <= POS_SUMEND) begin
				sum_q <= sum_q + {8'h00, s_tdata};
			end
			if (pos_q == POS_CMD) begin
				cmd_q <= s_tdata;
			end
			if (pos_q == POS_PAR_HI) begin
				par_hi_q <= s_tdata;
			end
			if (pos_q == POS_PAR_LO) begin
				par_lo_q <= s_tdata;
			end
			if (pos_q == POS_CHK_HI) begin
				chk_hi_q <= s_tdata;
			end
			if (pos_q == POS_CHK_LO) begin
				chk_ok_q <= (chk_total == 16'h0000);
			end
		end
	end

	// Output register with a skid entry behind it. While the skid is full no
	// input is taken, so no new result can arrive in that time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || out_take) begin
			if (res_valid) begin
				out_data_q <= res_data;
			end
		end else if (res_valid) begin
			skid_data_q <= res_data;
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_frame_check_pkg.sv =====
// ----------------------------------------------------------------------------
// tb_frame_check_pkg: frame prediction and result checking
// Tracks the parser state from the accepted input words, queues the command
// and parameter of every frame that should pass, and compares output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_frame_check_pkg;

	import afr_pkg::*;

	class frame_scoreboard;
		pos_t        rx_pos;
		logic [7:0]  rx_frame [FRAME_LEN];
		result_t     pending [$];
		int unsigned fail_count;

		function new();
			rx_pos = POS_START;
			fail_count = 0;
		endfunction

		// Notes one accepted input word. Returns 1 when the word was taken
		// into a frame, 0 when the parser dropped it.
		function bit note_rx_word(logic [7:0] rx_byte, logic line_error);
			pos_t        slot;
			logic [15:0] sum;
			logic [15:0] chk;
			result_t     good;
			if (line_error) begin
				rx_pos = POS_START;
				return 1'b0;
			end
			slot = (rx_pos > POS_LAST) ? POS_LAST : rx_pos;
			if (slot == POS_START && rx_byte != FRAME_START)
				return 1'b0;
			rx_frame[slot] = rx_byte;
			if (slot != POS_LAST) begin
				rx_pos = slot + pos_t'(1);
				return 1'b1;
			end
			rx_pos = POS_START;
			sum = 16'h0000;
			for (int k = POS_FIRST; k <= POS_SUMEND; k++)
				sum = sum + {8'h00, rx_frame[k]};
			chk = {rx_frame[POS_CHK_HI], rx_frame[POS_CHK_LO]};
			if (rx_frame[POS_LAST] == FRAME_END && 16'h0000 - sum == chk) begin
				good.frame_cmd   = rx_frame[POS_CMD];
				good.frame_param = {rx_frame[POS_PAR_HI], rx_frame[POS_PAR_LO]};
				pending.push_back(good);
			end
			return 1'b1;
		endfunction

		function void check_frame_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected frame word, expected none actual cmd %02h param %04h",
					$time, got.frame_cmd, got.frame_param);
				fail_count++;
				return;
			end
			want = pending.pop_front();
			if (got.frame_cmd !== want.frame_cmd) begin
				$display("%0t: frame_cmd mismatch, expected %02h actual %02h",
					$time, want.frame_cmd, got.frame_cmd);
				fail_count++;
			end
			if (got.frame_param !== want.frame_param) begin
				$display("%0t: frame_param mismatch, expected %04h actual %04h",
					$time, want.frame_param, got.frame_param);
				fail_count++;
			end
		endfunction
	endclass

endpackage

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the audio module frame receiver
// Sends serial byte words (directed cases, then random frames, noise and
// corrupted frames) under varied idling on both sides, and checks every
// output word against the predicted command and parameter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import afr_pkg::*;
	import tb_frame_check_pkg::*;

	localparam int TARGET_WORDS = 850;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		FRM_GOOD,
		FRM_BAD_SUM,
		FRM_BAD_END,
		FRM_LINE_ERR
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	frame_scoreboard sb;
	int          in_idle_pct;
	int          out_stall_pct;
	int          stored_words;
	int          cycle_count;
	logic [7:0]  frm [FRAME_LEN];

	audio_module_frame_receiver uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver decides afresh at every falling edge whether to stall.
	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_frame_result(result_t'(m_tdata));
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with s_tvalid still high, so back-to-back words never drop it.
	task automatic send_word(input logic [7:0] rx_byte, input logic line_error);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = 8'($urandom);
			s_tuser  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = rx_byte;
		s_tuser  = line_error;
		do
			@(posedge clk);
		while (!s_tready);
		if (sb.note_rx_word(rx_byte, line_error))
			stored_words++;
		@(negedge clk);
	endtask

	// Fills frm with a well-formed frame: correct checksum and end byte.
	task automatic fill_frame(input logic [7:0] ver, input logic [7:0] len,
			input logic [7:0] cmd, input logic [7:0] fback, input logic [15:0] param);
		logic [15:0] sum;
		frm[POS_START]  = FRAME_START;
		frm[1]          = ver;
		frm[2]          = len;
		frm[POS_CMD]    = cmd;
		frm[4]          = fback;
		frm[POS_PAR_HI] = param[15:8];
		frm[POS_PAR_LO] = param[7:0];
		sum = 16'h0000;
		for (int k = POS_FIRST; k <= POS_SUMEND; k++)
			sum = sum + {8'h00, frm[k]};
		sum = 16'h0000 - sum;
		frm[POS_CHK_HI] = sum[15:8];
		frm[POS_CHK_LO] = sum[7:0];
		frm[POS_LAST]   = FRAME_END;
	endtask

	// Sends frm; a line error word goes in just before byte err_at, unless
	// err_at is past the end of the frame.
	task automatic send_frame(input int err_at);
		for (int k = 0; k < FRAME_LEN; k++) begin
			if (k == err_at)
				send_word(8'($urandom), 1'b1);
			send_word(frm[k], 1'b0);
		end
	endtask

	// Leans towards the values that matter to the parser and the checksum.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return FRAME_START;
			3:       return FRAME_END;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_traffic(input int word_goal);
		frame_kind_t kind;
		int          roll;
		int          err_at;
		logic [7:0]  flip;
		while (stored_words < word_goal) begin
			if ($urandom_range(0, 99) < 15) begin
				// Line noise between frames, now and then with a line error.
				repeat ($urandom_range(1, 3))
					send_word(8'($urandom), ($urandom_range(0, 9) == 0));
			end else begin
				fill_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
					{pick_byte(), pick_byte()});
				roll = $urandom_range(0, 99);
				kind = (roll < 70) ? FRM_GOOD : (roll < 82) ? FRM_BAD_SUM :
					(roll < 90) ? FRM_BAD_END : FRM_LINE_ERR;
				err_at = FRAME_LEN;
				flip = 8'($urandom_range(1, 255));
				case (kind)
					FRM_BAD_SUM: begin
						if ($urandom_range(0, 1))
							frm[POS_CHK_HI] = frm[POS_CHK_HI] ^ flip;
						else
							frm[POS_CHK_LO] = frm[POS_CHK_LO] ^ flip;
					end
					FRM_BAD_END:  frm[POS_LAST] = FRAME_END ^ flip;
					FRM_LINE_ERR: err_at = $urandom_range(1, FRAME_LEN - 1);
					default: ;
				endcase
				send_frame(err_at);
			end
		end
	endtask

	// Holds the sender off until every predicted frame word has come out.
	task automatic wait_for_results();
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		s_tuser       = 1'b0;
		m_tready      = 1'b0;
		in_idle_pct   = 0;
		out_stall_pct = 0;
		stored_words  = 0;
		cycle_count   = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Junk while hunting, then a start byte that arrives with a line error.
		send_word(8'h00, 1'b0);
		send_word(FRAME_START, 1'b1);
		// Good frame with a start byte as data and the largest command and parameter.
		fill_frame(FRAME_START, 8'h06, 8'hFF, 8'h00, 16'hFFFF);
		send_frame(FRAME_LEN);
		// Bad end byte that is itself a start byte: it must not open a frame.
		fill_frame(8'hFF, 8'hFF, 8'h00, 8'hFF, 16'h0000);
		frm[POS_LAST] = FRAME_START;
		send_frame(FRAME_LEN);
		// A line error in the middle of a frame.
		send_word(FRAME_START, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		wait_for_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1:       begin in_idle_pct = 71; out_stall_pct = 0;  end
				2:       begin in_idle_pct = 0;  out_stall_pct = 71; end
				default: begin in_idle_pct = 21; out_stall_pct = 21; end
			endcase
			random_traffic(stored_words + TARGET_WORDS / 4);
			wait_for_results();
		end

		out_stall_pct = 0;
		s_tvalid = 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== audio_module_frame_receiver.f =====
src/afr_pkg.sv
src/audio_module_frame_receiver.sv
verif/tb_frame_check_pkg.sv
verif/tb_top.sv
